// ===== rtl/bumpa_pkg.sv =====
package bumpa_pkg;

  localparam int CNT_W = 31;
  localparam int VAL_W = 30;
  localparam int ALU_W = 32;

  localparam logic [CNT_W-1:0] MIN_ARENA  = 31'd64;
  localparam logic [CNT_W-1:0] MAX_ARENA  = 31'h4000_0000;
  localparam logic [CNT_W-1:0] MAX_COUNT  = 31'h0400_0000;
  localparam logic [CNT_W-1:0] ALIGN_MASK = 31'd15;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RESET   = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_NOT_LIVE  = 3'd3,
    ST_BAD_COUNT = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALIGN,
    S_DIFF,
    S_FIT,
    S_BUMP,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic             live_set;
    logic             live_clr;
    logic             cap_we;
    logic             off_we;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] off;
  } tbl_wr_t;

endpackage

// ===== rtl/bumpa_alu.sv =====
module bumpa_alu import bumpa_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] sum
);

  logic             is_sub;
  logic [ALU_W-1:0] b_eff;

  assign is_sub = (op == ALU_SUB);
  assign b_eff  = is_sub ? ~b : b;
  assign sum    = a + b_eff + {{(ALU_W-1){1'b0}}, is_sub};

endmodule

// ===== rtl/bumpa_table.sv =====
module bumpa_table import bumpa_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
  output logic                         live_rd,
  output logic [CNT_W-1:0]             cap_q,
  output logic [CNT_W-1:0]             off_q,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
  input  tbl_wr_t                      wr
);

  logic [NUM_SLOTS-1:0] live_r;
  logic [CNT_W-1:0]     cap_mem [NUM_SLOTS];
  logic [CNT_W-1:0]     off_mem [NUM_SLOTS];

  assign live_rd = live_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (wr.live_set) begin
      live_r[wr_addr] <= 1'b1;
    end else if (wr.live_clr) begin
      live_r[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.cap_we) begin
      cap_mem[wr_addr] <= wr.cap;
    end
    if (wr.off_we) begin
      off_mem[wr_addr] <= wr.off;
    end
    cap_q <= cap_mem[rd_addr];
    off_q <= off_mem[rd_addr];
  end

endmodule

// ===== rtl/bump_arena_slot_allocator_unit.sv =====
// Bump arena slot allocator: a table of NUM_SLOTS arenas (live flag, capacity, bump offset)
// serving create, allocate, reset and destroy requests, one at a time, one result each.
// Reset, destroy and every request rejected on its fields go straight to the result; allocate
// uses one shared 32-bit adder in four steps (align, capacity minus offset, fit check, bump)
// and ends after the second or third step when it fails as full; create finds the first free
// slot by testing one live flag per cycle from slot 0. Offsets are rounded up to 16 bytes
// before each allocate, and that rounding is kept even when the allocate then fails as full.
// in_stall is high from acceptance until the result has been taken. No clearing pass is needed
// after reset.
module bump_arena_slot_allocator_unit import bumpa_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [4:0]       in_slot_id,
  input  logic [CNT_W-1:0] in_byte_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_ok,
  output logic [2:0]       out_status,
  output logic [VAL_W-1:0] out_value
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [8:0] SLOTS_EXT = 9'(NUM_SLOTS);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] id_r, id_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] off_al_r, off_al_nxt;
  logic [CNT_W-1:0] diff_r, diff_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;

  logic [8:0]       id_ext;
  logic             in_range;
  logic [IDX_W-1:0] in_addr;

  logic [IDX_W-1:0] tbl_addr;
  logic             live_rd;
  logic [CNT_W-1:0] cap_q;
  logic [CNT_W-1:0] off_q;
  logic [IDX_W-1:0] wr_addr;
  tbl_wr_t          wr;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_sum;

  assign id_ext   = {4'b0000, in_slot_id};
  assign in_range = (id_ext < SLOTS_EXT);
  assign in_addr  = id_ext[IDX_W-1:0];

  assign in_stall   = (state_r != S_IDLE) || !rst_n;
  assign out_valid  = (state_r == S_DONE);
  assign out_status = out_status_r;
  assign out_ok     = (out_status_r == ST_OK);
  assign out_value  = out_value_r;

  bumpa_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (tbl_addr),
    .live_rd (live_rd),
    .cap_q   (cap_q),
    .off_q   (off_q),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  bumpa_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    off_al_r     <= off_al_nxt;
    diff_r       <= diff_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    id_nxt         = id_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    off_al_nxt     = off_al_r;
    diff_nxt       = diff_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    tbl_addr       = id_r;
    wr_addr        = id_r;
    wr             = '0;
    alu_op         = ALU_ADD;
    alu_a          = '0;
    alu_b          = '0;

    case (state_r)
      S_IDLE: begin
        tbl_addr = in_addr;
        if (in_valid && rst_n) begin
          id_nxt         = in_addr;
          n_nxt          = in_byte_count;
          idx_nxt        = '0;
          out_status_nxt = ST_OK;
          out_value_nxt  = '0;
          state_nxt      = S_DONE;
          case (cmd_t'(in_cmd))
            CMD_CREATE: begin
              if (in_byte_count < MIN_ARENA || in_byte_count > MAX_ARENA) begin
                out_status_nxt = ST_BAD_SIZE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_ALLOC: begin
              if (in_byte_count == '0) begin
                out_status_nxt = ST_BAD_COUNT;
              end else if (!in_range) begin
                out_status_nxt = ST_NOT_LIVE;
              end else if (in_byte_count > MAX_COUNT) begin
                out_status_nxt = ST_BAD_COUNT;
              end else if (!live_rd) begin
                out_status_nxt = ST_NOT_LIVE;
              end else begin
                state_nxt = S_ALIGN;
              end
            end
            CMD_RESET: begin
              if (!in_range || !live_rd) begin
                out_status_nxt = ST_NOT_LIVE;
              end else begin
                wr_addr   = in_addr;
                wr.off_we = 1'b1;
              end
            end
            CMD_DESTROY: begin
              if (!in_range || !live_rd) begin
                out_status_nxt = ST_NOT_LIVE;
              end else begin
                wr_addr     = in_addr;
                wr.live_clr = 1'b1;
              end
            end
            default: begin
              out_status_nxt = ST_NOT_LIVE;
            end
          endcase
        end
      end

      // first free slot, one flag per cycle
      S_SCAN: begin
        tbl_addr = idx_r;
        if (!live_rd) begin
          wr_addr       = idx_r;
          wr.live_set   = 1'b1;
          wr.cap_we     = 1'b1;
          wr.cap        = n_r;
          wr.off_we     = 1'b1;
          out_value_nxt = VAL_W'(idx_r);
          state_nxt     = S_DONE;
        end else if (idx_r == LAST_IDX) begin
          out_status_nxt = ST_NO_SLOT;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_ALIGN: begin
        alu_op     = ALU_ADD;
        alu_a      = {1'b0, off_q};
        alu_b      = {1'b0, ALIGN_MASK};
        off_al_nxt = alu_sum[CNT_W-1:0] & ~ALIGN_MASK;
        state_nxt  = S_DIFF;
      end

      // capacity minus aligned offset, borrow means full
      S_DIFF: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, cap_q};
        alu_b  = {1'b0, off_al_r};
        if (alu_sum[ALU_W-1]) begin
          wr.off_we      = 1'b1;
          wr.off         = off_al_r;
          out_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          diff_nxt  = alu_sum[CNT_W-1:0];
          state_nxt = S_FIT;
        end
      end

      S_FIT: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, diff_r};
        alu_b  = {1'b0, n_r};
        if (alu_sum[ALU_W-1]) begin
          wr.off_we      = 1'b1;
          wr.off         = off_al_r;
          out_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_BUMP;
        end
      end

      S_BUMP: begin
        alu_op        = ALU_ADD;
        alu_a         = {1'b0, off_al_r};
        alu_b         = {1'b0, n_r};
        wr.off_we     = 1'b1;
        wr.off        = alu_sum[CNT_W-1:0];
        out_value_nxt = off_al_r[VAL_W-1:0];
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bumpa_checker.sv =====
module bumpa_checker import bumpa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_ok,
  input logic [2:0]       out_status,
  input logic [VAL_W-1:0] out_value
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_value))
    else $error("stalled result changed");

  // one request in flight
  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_value == '0 && out_status != ST_OK)
    else $error("failed request with non-zero value");

endmodule

bind bump_arena_slot_allocator_unit bumpa_checker u_bumpa_checker (.*);

// ===== dv/bump_arena_slot_allocator_unit_test.sv =====
`timescale 1ns / 1ps

module bump_arena_slot_allocator_unit_test;
  import bumpa_pkg::*;

  localparam int SLOTS = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 450;

  typedef struct packed {
    logic             ok;
    status_t          status;
    logic [VAL_W-1:0] value;
  } alloc_result_t;

  class alloc_scoreboard;
    bit               live[SLOTS];
    logic [CNT_W-1:0] capacity[SLOTS];
    logic [CNT_W-1:0] offset[SLOTS];
    alloc_result_t    expected_q[$];
    int               errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        live[i] = 1'b0;
        capacity[i] = '0;
        offset[i] = '0;
      end
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function logic [CNT_W-1:0] aligned_offset(int idx);
      logic [ALU_W-1:0] sum;
      sum = ({1'b0, offset[idx]} + 32'd15) & ~32'd15;
      return sum[CNT_W-1:0];
    endfunction

    function alloc_result_t predict(cmd_t cmd, logic [4:0] slot, logic [CNT_W-1:0] count);
      alloc_result_t    r;
      logic [CNT_W-1:0] rounded;
      bit               found;
      r.ok = 1'b0;
      r.status = ST_OK;
      r.value = '0;
      found = 1'b0;
      case (cmd)
        CMD_CREATE: begin
          if (count < MIN_ARENA || count > MAX_ARENA) begin
            r.status = ST_BAD_SIZE;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!found && !live[i]) begin
                found = 1'b1;
                live[i] = 1'b1;
                capacity[i] = count;
                offset[i] = '0;
                r.value = VAL_W'(i);
              end
            end
            if (!found) r.status = ST_NO_SLOT;
          end
        end
        CMD_ALLOC: begin
          if (count == 0 || count > MAX_COUNT) begin
            r.status = ST_BAD_COUNT;
          end else if (!live[slot]) begin
            r.status = ST_NOT_LIVE;
          end else begin
            rounded = aligned_offset(slot);
            offset[slot] = rounded;
            if (rounded > capacity[slot] || count > capacity[slot] - rounded) begin
              r.status = ST_FULL;
            end else begin
              r.value = rounded[VAL_W-1:0];
              offset[slot] = rounded + count;
            end
          end
        end
        CMD_RESET: begin
          if (!live[slot]) r.status = ST_NOT_LIVE;
          else offset[slot] = '0;
        end
        default: begin
          if (!live[slot]) begin
            r.status = ST_NOT_LIVE;
          end else begin
            live[slot] = 1'b0;
            capacity[slot] = '0;
            offset[slot] = '0;
          end
        end
      endcase
      r.ok = (r.status == ST_OK);
      return r;
    endfunction

    function void note_request(cmd_t cmd, logic [4:0] slot, logic [CNT_W-1:0] count);
      expected_q.push_back(predict(cmd, slot, count));
    endfunction

    task check_result(logic ok, logic [2:0] status, logic [VAL_W-1:0] value);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result ok=%0d status=%0d value=%0d", ok, status, value));
      end else begin
        want = expected_q.pop_front();
        if (ok !== want.ok)
          report($sformatf("ok got %0d expected %0d", ok, want.ok));
        if (status !== want.status)
          report($sformatf("status got %0d expected %0d", status, want.status));
        if (value !== want.value)
          report($sformatf("value got %0d expected %0d", value, want.value));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_cmd = '0;
  logic [4:0]       in_slot_id = '0;
  logic [CNT_W-1:0] in_byte_count = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_ok;
  logic [2:0]       out_status;
  logic [VAL_W-1:0] out_value;

  alloc_scoreboard sb = new();
  int in_idle_pct = 34;
  int out_idle_pct = 59;
  int quiet_cycles = 0;

  bump_arena_slot_allocator_unit #(.NUM_SLOTS(SLOTS)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_slot_id    (in_slot_id),
    .in_byte_count (in_byte_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_status    (out_status),
    .out_value     (out_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_ok, out_status, out_value);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task send(cmd_t cmd, logic [4:0] slot, logic [CNT_W-1:0] count);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_slot_id <= slot;
    in_byte_count <= count;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, slot, count);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [CNT_W-1:0] rand_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return CNT_W'($urandom_range(64, 1024));
    else if (pick < 70) return CNT_W'($urandom_range(64, 1 << 20));
    else if (pick < 80) return CNT_W'($urandom_range(64, 1 << 30));
    else if (pick < 85) return MIN_ARENA;
    else if (pick < 90) return MAX_ARENA;
    else if (pick < 95) return CNT_W'($urandom_range(0, 63));
    else return CNT_W'($urandom_range(32'h4000_0001, 32'h7fff_ffff));
  endfunction

  function logic [CNT_W-1:0] rand_count(int slot);
    int               pick;
    logic [CNT_W-1:0] rounded;
    logic [CNT_W-1:0] room;
    pick = $urandom_range(99);
    rounded = sb.aligned_offset(slot);
    room = (rounded < sb.capacity[slot]) ? sb.capacity[slot] - rounded : '0;
    if (pick < 55) return CNT_W'($urandom_range(1, 256));
    else if (pick < 70 && sb.capacity[slot] != 0)
      return CNT_W'($urandom_range(1, (sb.capacity[slot] > MAX_COUNT) ? MAX_COUNT
                                                                     : sb.capacity[slot]));
    else if (pick < 82 && room != 0) return (room > MAX_COUNT) ? MAX_COUNT : room;
    else if (pick < 87) return '0;
    else if (pick < 93) return MAX_COUNT;
    else if (pick < 97) return CNT_W'(MAX_COUNT + 1);
    else return CNT_W'($urandom & 32'h7fff_ffff);
  endfunction

  function logic [4:0] pick_slot();
    int live_ids[$];
    for (int i = 0; i < SLOTS; i++) if (sb.live[i]) live_ids.push_back(i);
    if (live_ids.size() == 0 || $urandom_range(9) == 0) return 5'($urandom_range(SLOTS - 1));
    return 5'(live_ids[$urandom_range(live_ids.size() - 1)]);
  endfunction

  task run_random(int n_items);
    int         done;
    int         pick;
    logic [4:0] slot;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      slot = pick_slot();
      if (pick < 28) begin
        send(CMD_CREATE, 5'($urandom_range(SLOTS - 1)), rand_size());
        done++;
      end else if (pick < 70) begin
        send(CMD_ALLOC, slot, rand_count(slot));
        done++;
      end else if (pick < 78) begin
        send(CMD_RESET, slot, CNT_W'($urandom & 32'h7fff_ffff));
        done++;
      end else if (pick < 89) begin
        send(CMD_DESTROY, slot, CNT_W'($urandom & 32'h7fff_ffff));
        done++;
      end else if (pick < 92) begin
        // fill the table and run one create past the end
        for (int i = 0; i <= SLOTS && done < n_items; i++) begin
          send(CMD_CREATE, 5'($urandom_range(SLOTS - 1)), CNT_W'($urandom_range(64, 4096)));
          done++;
          if (sb.pending() > 0 && sb.expected_q[$].status == ST_NO_SLOT) break;
        end
      end else begin
        send(cmd_t'($urandom_range(3)), 5'($urandom_range(SLOTS - 1)),
             CNT_W'($urandom & 32'h7fff_ffff));
        done++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size limits on create
    send(CMD_CREATE, 5'd0, 31'd63);
    send(CMD_CREATE, 5'd0, MIN_ARENA);
    send(CMD_CREATE, 5'd31, MAX_ARENA);
    send(CMD_CREATE, 5'd0, CNT_W'(MAX_ARENA + 1));
    send(CMD_CREATE, 5'd0, '0);
    send(CMD_CREATE, 5'd0, 31'h7fff_ffff);
    // count limits and alignment on allocate
    send(CMD_ALLOC, 5'd0, '0);
    send(CMD_ALLOC, 5'd0, CNT_W'(MAX_COUNT + 1));
    send(CMD_ALLOC, 5'd31, 31'd1);
    send(CMD_ALLOC, 5'd0, 31'd1);
    send(CMD_ALLOC, 5'd0, 31'd1);
    send(CMD_ALLOC, 5'd0, 31'd48);
    send(CMD_ALLOC, 5'd0, 31'd32);
    send(CMD_ALLOC, 5'd0, 31'd1);
    send(CMD_ALLOC, 5'd1, MAX_COUNT);
    // reset and destroy, live and not
    send(CMD_RESET, 5'd0, 31'h7fff_ffff);
    send(CMD_RESET, 5'd5, '0);
    send(CMD_DESTROY, 5'd5, '0);
    send(CMD_DESTROY, 5'd0, 31'h7fff_ffff);
    send(CMD_ALLOC, 5'd0, 31'd1);
    // rounded offset passing the capacity
    send(CMD_CREATE, 5'd0, 31'd70);
    send(CMD_ALLOC, 5'd0, 31'd65);
    send(CMD_ALLOC, 5'd0, 31'd1);
    send(CMD_RESET, 5'd0, '0);
    send(CMD_ALLOC, 5'd0, 31'd70);

    run_random(RANDOM_PER_PHASE);
    drain();
    in_idle_pct = 59;
    out_idle_pct = 34;
    run_random(RANDOM_PER_PHASE);
    drain();
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    drain();
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bumpa_pkg.sv
rtl/bumpa_alu.sv
rtl/bumpa_table.sv
rtl/bump_arena_slot_allocator_unit.sv
rtl/bumpa_checker.sv
dv/bump_arena_slot_allocator_unit_test.sv
